>>> rtl/packed_pixel_palette_expander_macros.svh
// Assertion macros shared by the packed pixel palette expander checkers.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef PACKED_PIXEL_PALETTE_EXPANDER_MACROS_SVH
`define PACKED_PIXEL_PALETTE_EXPANDER_MACROS_SVH

// General property, checked on every rising clock edge outside reset.
`define PPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Signal must hold its value on the cycle after cond.
`define PPE_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> rtl/ppe_pkg.sv
// Package for the packed pixel palette expander: widths, register and
// depth codes, and the structs passed between its modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam int ByteW   = 8;
  localparam int ColourW = 16;
  localparam int IdxW    = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;
  localparam int RepCfgW = 3;
  localparam int EntriesPerWord = CfgDataW / ColourW;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_DEPTH      = 3'd0,
    REG_HORIZ_REPEAT     = 3'd1,
    REG_PALETTE_LOW      = 3'd2,
    REG_PALETTE_MID_LOW  = 3'd3,
    REG_PALETTE_MID_HIGH = 3'd4,
    REG_PALETTE_HIGH     = 3'd5
  } ppe_reg_e;

  typedef enum logic [1:0] {
    DEPTH_1BIT = 2'd0,
    DEPTH_2BIT = 2'd1,
    DEPTH_4BIT = 2'd2
  } ppe_depth_e;

  typedef struct packed {
    logic [1:0]         depth;
    logic [RepCfgW-1:0] h_repeat;
  } ppe_cfg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic            last;
  } ppe_pix_t;

endpackage

`default_nettype wire

>>> rtl/ppe_ifs.sv
// Valid/ready channel interfaces: packed bytes in, palette pixels out.
// Depends on ppe_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface ppe_byte_if;
  logic                       valid;
  logic                       ready;
  logic [ppe_pkg::ByteW-1:0]  pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface ppe_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [ppe_pkg::ColourW-1:0] pixel_colour;
  logic                        last_of_byte;

  modport source (output valid, output pixel_colour, output last_of_byte, input ready);
  modport sink   (input valid, input pixel_colour, input last_of_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/ppe_cfg_regs.sv
// Configuration registers and palette storage with the colour lookup.
// Depends on ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_cfg_regs #(
  parameter int PALETTE_SIZE = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ppe_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [ppe_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic [ppe_pkg::IdxW-1:0]       idx_i,
  output ppe_pkg::ppe_cfg_t                   cfg_o,
  output logic [ppe_pkg::ColourW-1:0]         colour_o
);

  localparam int PalIdxW = $clog2(PALETTE_SIZE);

  ppe_pkg::ppe_cfg_t cfg_q;
  logic [ppe_pkg::ColourW-1:0] entry_q [PALETTE_SIZE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth    <= ppe_pkg::DEPTH_2BIT;
      cfg_q.h_repeat <= ppe_pkg::RepCfgW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == ppe_pkg::REG_PIXEL_DEPTH) begin
        cfg_q.depth <= cfg_data_i[1:0];
      end
      if (cfg_index_i == ppe_pkg::REG_HORIZ_REPEAT) begin
        cfg_q.h_repeat <= cfg_data_i[ppe_pkg::RepCfgW-1:0];
      end
    end
  end

  for (genvar g = 0; g < PALETTE_SIZE; g++) begin : gen_entry
    localparam int Word = g / ppe_pkg::EntriesPerWord;
    localparam int Lane = g % ppe_pkg::EntriesPerWord;
    localparam logic [ppe_pkg::CfgIdxW-1:0] Addr =
      ppe_pkg::CfgIdxW'(int'(ppe_pkg::REG_PALETTE_LOW) + Word);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        entry_q[g] <= '0;
      end else if (cfg_we_i && (cfg_index_i == Addr)) begin
        entry_q[g] <= cfg_data_i[Lane*ppe_pkg::ColourW +: ppe_pkg::ColourW];
      end
    end
  end

  // Indices past the stored palette read as black.
  always_comb begin
    if ({1'b0, idx_i} < (ppe_pkg::IdxW + 1)'(PALETTE_SIZE)) begin
      colour_o = entry_q[idx_i[PalIdxW-1:0]];
    end else begin
      colour_o = '0;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/ppe_unpack.sv
// Byte holding stage: takes one packed byte, steps through its pixel slots
// and repeat copies, and presents one palette index per cycle while advance_i is high. Uses ppe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppe_unpack #(
  parameter int MAX_REPEAT = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ppe_byte_if.sink               byte_i,
  input  wire ppe_pkg::ppe_cfg_t cfg_i,
  input  wire logic              advance_i,
  output ppe_pkg::ppe_pix_t      pix_o
);

  localparam int RepW = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;

  logic                       hold_q;
  logic [ppe_pkg::ByteW-1:0]  byte_q;
  logic [2:0]                 slot_q;
  logic [RepW-1:0]            rep_q;

  logic [ppe_pkg::RepCfgW:0]  rep_sat;
  logic [RepW-1:0]            reps_m1;
  logic                       rep_last;
  logic                       slot_last;
  logic [ppe_pkg::IdxW-1:0]   idx;
  logic                       accept;

  // Zero repeats means one copy; large values clamp to the maximum.
  always_comb begin
    priority if (cfg_i.h_repeat == '0) begin
      rep_sat = (ppe_pkg::RepCfgW + 1)'(1);
    end else if ({1'b0, cfg_i.h_repeat} > (ppe_pkg::RepCfgW + 1)'(MAX_REPEAT)) begin
      rep_sat = (ppe_pkg::RepCfgW + 1)'(MAX_REPEAT);
    end else begin
      rep_sat = {1'b0, cfg_i.h_repeat};
    end
  end

  assign reps_m1  = RepW'(rep_sat - (ppe_pkg::RepCfgW + 1)'(1));
  assign rep_last = (rep_q == reps_m1);

  always_comb begin
    unique case (cfg_i.depth)
      ppe_pkg::DEPTH_1BIT: begin
        idx       = {3'b000, byte_q[slot_q]};
        slot_last = (slot_q == 3'd7);
      end
      ppe_pkg::DEPTH_2BIT: begin
        idx       = {2'b00, byte_q[{slot_q[1:0], 1'b0} +: 2]};
        slot_last = (slot_q[1:0] == 2'd3);
      end
      default: begin
        // four bits per pixel, also for the unused depth code
        idx       = byte_q[{slot_q[0], 2'b00} +: 4];
        slot_last = slot_q[0];
      end
    endcase
  end

  assign pix_o.valid = hold_q;
  assign pix_o.idx   = idx;
  assign pix_o.last  = slot_last && rep_last;

  // Take the next byte while the last pixel of this one moves out.
  assign byte_i.ready = !hold_q || (advance_i && pix_o.last);
  assign accept       = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      byte_q <= '0;
      slot_q <= '0;
      rep_q  <= '0;
    end else if (accept) begin
      hold_q <= 1'b1;
      byte_q <= byte_i.pixel_byte;
      slot_q <= '0;
      rep_q  <= '0;
    end else if (advance_i) begin
      priority if (pix_o.last) begin
        hold_q <= 1'b0;
        slot_q <= '0;
        rep_q  <= '0;
      end else if (rep_last) begin
        rep_q  <= '0;
        slot_q <= slot_q + 3'd1;
      end else begin
        rep_q  <= rep_q + RepW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/ppe_out_stage.sv
// Result register: holds one colour and its last flag until the sink takes it.
// Uses ppe_pkg and the pixel channel interface.
`timescale 1ns / 1ps
`default_nettype none

module ppe_out_stage (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ppe_pkg::ppe_pix_t       pix_i,
  input  wire logic [ppe_pkg::ColourW-1:0] colour_i,
  output logic                         take_o,
  ppe_pixel_if.source                  pixel_o
);

  logic                        valid_q;
  logic [ppe_pkg::ColourW-1:0] colour_q;
  logic                        last_q;

  assign take_o = pix_i.valid && (!valid_q || pixel_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (pixel_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      colour_q <= colour_i;
      last_q   <= pix_i.last;
    end
  end

  assign pixel_o.valid        = valid_q;
  assign pixel_o.pixel_colour = colour_q;
  assign pixel_o.last_of_byte = last_q;

endmodule

`default_nettype wire

>>> rtl/packed_pixel_palette_expander.sv
// Packed pixel palette expander, top level.
// First pixel: the byte is held in the unpack stage, then its first colour goes into the result register.
// Throughput: one pixel per cycle while the sink is ready; a byte gives
// (8 / bits per pixel) times the repeat count pixels, 2 to 32.
// Bytes follow back to back with no gap between their pixels.
// Reset: clears all control and the palette (black), depth 2 bits, repeat 1.
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_palette_expander #(
  parameter int PALETTE_SIZE = 16,
  parameter int MAX_REPEAT   = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ppe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ppe_pkg::CfgDataW-1:0] cfg_data_i,
  ppe_byte_if.sink                          byte_i,
  ppe_pixel_if.source                       pixel_o
);

  ppe_pkg::ppe_cfg_t           cfg;
  ppe_pkg::ppe_pix_t           pix;
  logic [ppe_pkg::ColourW-1:0] colour;
  logic                        advance;

  ppe_cfg_regs #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .idx_i       (pix.idx),
    .cfg_o       (cfg),
    .colour_o    (colour)
  );

  ppe_unpack #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_unpack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .cfg_i     (cfg),
    .advance_i (advance),
    .pix_o     (pix)
  );

  ppe_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix),
    .colour_i (colour),
    .take_o   (advance),
    .pixel_o  (pixel_o)
  );

endmodule

`default_nettype wire

>>> rtl/ppe_checker.sv
// Port-level checker for the packed pixel palette expander, bound to the top.
// Uses the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "packed_pixel_palette_expander_macros.svh"

module ppe_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [ppe_pkg::ColourW-1:0] out_colour_i,
  input wire logic                        out_last_i
);

  logic       in_acc;
  logic       out_end;
  logic [1:0] open_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_end = out_valid_i && out_ready_i && out_last_i;

  // Count bytes taken whose last pixel has not left yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_acc && !out_end) begin
      open_q <= open_q + 2'd1;
    end else if (!in_acc && out_end) begin
      open_q <= open_q - 2'd1;
    end
  end

  `PPE_ASSERT(a_no_stray_last, out_end |-> (open_q != 2'd0), "last pixel with no byte open")
  `PPE_ASSERT(a_open_bounded, open_q != 2'd3, "more than two bytes in flight")
  `PPE_ASSERT(a_first_pixel, in_acc |-> ##2 out_valid_i, "no pixel after byte taken")
  `PPE_ASSERT_HOLD(a_stall_hold, out_valid_i && !out_ready_i, {out_valid_i, out_colour_i, out_last_i}, "stalled pixel changed")

endmodule

bind packed_pixel_palette_expander ppe_checker u_ppe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .out_valid_i  (pixel_o.valid),
  .out_ready_i  (pixel_o.ready),
  .out_colour_i (pixel_o.pixel_colour),
  .out_last_i   (pixel_o.last_of_byte)
);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for packed_pixel_palette_expander: bytes in, RGB565 pixels out.
// Depends on ppe_pkg and the ppe_byte_if / ppe_pixel_if interfaces from the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int PaletteSize  = 16;
  localparam int MaxRepeat    = 4;
  localparam int ItemTarget   = 350;
  localparam int SettleCycles = 4;
  localparam int StallLimit   = 4000;

  // Indexes outside the register map; writes there must change nothing.
  localparam logic [ppe_pkg::CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [ppe_pkg::CfgIdxW-1:0] RegSpareHigh = 3'd7;

  typedef struct {
    bit [ppe_pkg::ColourW-1:0] colour;
    bit                        last;
  } pixel_t;

  class PixelExpansionScoreboard;
    bit [1:0]                   depth_code;
    bit [ppe_pkg::RepCfgW-1:0]  repeat_code;
    bit [ppe_pkg::CfgDataW-1:0] palette_word[4];
    pixel_t                     expected_pixels[$];
    int unsigned                mismatches;
    int unsigned                pixels_seen;
    int unsigned                bytes_seen;

    function new();
      depth_code  = ppe_pkg::DEPTH_2BIT;
      repeat_code = 1;
      foreach (palette_word[k]) palette_word[k] = '0;
    endfunction

    function void write_reg(logic [ppe_pkg::CfgIdxW-1:0] idx,
                            logic [ppe_pkg::CfgDataW-1:0] data);
      case (idx)
        ppe_pkg::REG_PIXEL_DEPTH:  depth_code  = data[1:0];
        ppe_pkg::REG_HORIZ_REPEAT: repeat_code = data[ppe_pkg::RepCfgW-1:0];
        ppe_pkg::REG_PALETTE_LOW, ppe_pkg::REG_PALETTE_MID_LOW,
        ppe_pkg::REG_PALETTE_MID_HIGH, ppe_pkg::REG_PALETTE_HIGH:
          palette_word[int'(idx) - int'(ppe_pkg::REG_PALETTE_LOW)] = data;
        default: ;
      endcase
    endfunction

    function bit [ppe_pkg::ColourW-1:0] colour_of(bit [ppe_pkg::IdxW-1:0] idx);
      if (idx >= PaletteSize) return '0;
      return palette_word[idx[3:2]][idx[1:0]*ppe_pkg::ColourW +: ppe_pkg::ColourW];
    endfunction

    function void note_byte(bit [ppe_pkg::ByteW-1:0] packed_byte);
      int unsigned bits;
      int unsigned npix;
      int unsigned reps;
      bit [ppe_pkg::IdxW-1:0] idx;
      pixel_t px;
      case (depth_code)
        ppe_pkg::DEPTH_1BIT: bits = 1;
        ppe_pkg::DEPTH_2BIT: bits = 2;
        default:             bits = 4;
      endcase
      npix = ppe_pkg::ByteW / bits;
      reps = (repeat_code == 0) ? 1 : (repeat_code > MaxRepeat) ? MaxRepeat : repeat_code;
      for (int unsigned p = 0; p < npix; p++) begin
        idx = ppe_pkg::IdxW'((packed_byte >> (p * bits)) & ((1 << bits) - 1));
        for (int unsigned r = 0; r < reps; r++) begin
          px.colour = colour_of(idx);
          px.last   = (p == npix - 1) && (r == reps - 1);
          expected_pixels.push_back(px);
        end
      end
      bytes_seen++;
    endfunction

    function void check_pixel(logic [ppe_pkg::ColourW-1:0] colour, logic last);
      pixel_t px;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_colour %h last_of_byte %b", colour, last);
        mismatches++;
        return;
      end
      px = expected_pixels.pop_front();
      if (colour !== px.colour) begin
        $error("pixel_colour: expected %h, got %h", px.colour, colour);
        mismatches++;
      end
      if (last !== px.last) begin
        $error("last_of_byte: expected %b, got %b", px.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [ppe_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [ppe_pkg::CfgDataW-1:0] cfg_data_i;

  ppe_byte_if  byte_if ();
  ppe_pixel_if pixel_if ();

  packed_pixel_palette_expander #(
    .PALETTE_SIZE(PaletteSize),
    .MAX_REPEAT  (MaxRepeat)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .byte_i     (byte_if),
    .pixel_o    (pixel_if)
  );

  PixelExpansionScoreboard sb = new();

  logic [ppe_pkg::ByteW-1:0] byte_plan[$];
  bit [31:0]        ready_pattern = '1;
  bit               sender_idles = 1'b1;
  int unsigned      burst_left = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      setting_count = 0;

  always #5 clk_i = ~clk_i;

  // End the run when neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_if.valid && byte_if.ready) || (pixel_if.valid && pixel_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic set_reg(input logic [ppe_pkg::CfgIdxW-1:0] idx,
                         input logic [ppe_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_palette(input logic [ppe_pkg::CfgDataW-1:0] w0,
                              input logic [ppe_pkg::CfgDataW-1:0] w1,
                              input logic [ppe_pkg::CfgDataW-1:0] w2,
                              input logic [ppe_pkg::CfgDataW-1:0] w3);
    set_reg(ppe_pkg::REG_PALETTE_LOW, w0);
    set_reg(ppe_pkg::REG_PALETTE_MID_LOW, w1);
    set_reg(ppe_pkg::REG_PALETTE_MID_HIGH, w2);
    set_reg(ppe_pkg::REG_PALETTE_HIGH, w3);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_format(input logic [ppe_pkg::CfgDataW-1:0] depth_data,
                              input logic [ppe_pkg::CfgDataW-1:0] repeat_data);
    set_reg(ppe_pkg::REG_PIXEL_DEPTH, depth_data);
    set_reg(ppe_pkg::REG_HORIZ_REPEAT, repeat_data);
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  // Push every planned byte through in bursts, with random gaps between them while the sender idles.
  task automatic send_plan();
    int unsigned gap;
    foreach (byte_plan[k]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 6);
        gap = sender_idles ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
          byte_if.valid      <= 1'b0;
          byte_if.pixel_byte <= $urandom;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      byte_if.valid      <= 1'b1;
      byte_if.pixel_byte <= byte_plan[k];
      do @(posedge clk_i); while (!byte_if.ready);
      sb.note_byte(byte_plan[k]);
    end
    byte_if.valid <= 1'b0;
  endtask

  task automatic receive_pixels();
    int unsigned step = 0;
    forever begin
      pixel_if.ready <= ready_pattern[step % 32];
      step++;
      @(posedge clk_i);
      if (pixel_if.valid && pixel_if.ready) begin
        sb.check_pixel(pixel_if.pixel_colour, pixel_if.last_of_byte);
      end
    end
  endtask

  // Hold until every expected pixel is out, then let the pipeline go quiet.
  task automatic settle();
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned   count;
    logic [63:0]   junk;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= ppe_pkg::REG_PIXEL_DEPTH;
    cfg_data_i         <= '0;
    byte_if.valid      <= 1'b0;
    byte_if.pixel_byte <= '0;
    pixel_if.ready     <= 1'b0;
    rst_ni             <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      receive_pixels();
    join_none

    // Reset settings: two bits per pixel, no repeat, all black.
    byte_plan = '{8'h00, 8'hFF};
    send_plan();
    settle();

    load_palette(64'h1234_F800_07E0_0000, 64'h8421_4210_A5A5_5A5A,
                 64'hC3C3_3C3C_0F0F_F0F0, 64'hFFFF_7BEF_001F_FFE0);
    apply_format(ppe_pkg::DEPTH_1BIT, 1);
    byte_plan = '{8'h55, 8'hAA, 8'h01, 8'h80};
    send_plan();
    settle();

    ready_pattern = 32'hB6DB_6DB6;
    apply_format(ppe_pkg::DEPTH_2BIT, MaxRepeat);
    byte_plan = '{8'h1B, 8'hE4, 8'hFF};
    send_plan();
    settle();

    // Ignore bits above the field width.
    apply_format({62'h3FFF_FFFF_FFFF_FFFF, 2'(ppe_pkg::DEPTH_4BIT)}, 64'hFFFF_FFFF_FFFF_FFF9);
    byte_plan = '{8'h0F, 8'hF0, 8'h00, 8'hFF};
    send_plan();
    settle();

    // Depth code three saturates to four bits; repeat zero acts as one.
    apply_format(2'd3, 0);
    byte_plan = '{8'hA5, 8'h5A};
    send_plan();
    settle();

    // Repeat above the maximum saturates; spare indexes are ignored.
    set_reg(RegSpareLow, 64'hFFFF_FFFF_FFFF_FFFF);
    set_reg(RegSpareHigh, 64'hDEAD_BEEF_0000_0000);
    apply_format(ppe_pkg::DEPTH_1BIT, 7);
    byte_plan = '{8'h3C, 8'h00};
    send_plan();
    settle();

    ready_pattern = '1;
    sender_idles  = 1'b0;
    apply_format(ppe_pkg::DEPTH_2BIT, 5);
    byte_plan = '{8'hC6};
    send_plan();
    settle();

    apply_format(ppe_pkg::DEPTH_1BIT, MaxRepeat);
    byte_plan = '{8'h96, 8'h69};
    send_plan();
    settle();

    while (sb.bytes_seen < ItemTarget) begin
      if ($urandom_range(0, 2) == 0) begin
        load_palette({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      end
      if ($urandom_range(0, 4) == 0) begin
        set_reg($urandom_range(0, 1) ? RegSpareLow : RegSpareHigh, {$urandom, $urandom});
      end
      junk = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : '0;
      apply_format({junk[63:2], 2'($urandom_range(0, 3))},
                   {junk[63:3], 3'($urandom_range(0, 7))});
      // Mix stretches without idling among the stalled ones.
      if ($urandom_range(0, 3) == 0) begin
        sender_idles  = 1'b0;
        ready_pattern = '1;
      end else begin
        sender_idles  = 1'b1;
        ready_pattern = $urandom | 32'h1;
      end
      count = $urandom_range(8, 30);
      byte_plan.delete();
      repeat (count) byte_plan.push_back($urandom);
      send_plan();
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("Expanded %0d bytes into %0d pixels over %0d depth and repeat settings,",
             sb.bytes_seen, sb.pixels_seen, setting_count);
    $display("with fixed and random palettes, saturating codes and bursty handshakes.");
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
